/* rtl/text_line_number_filter_assert.svh */
// Assertion helpers shared by the checker files.
`ifndef TEXT_LINE_NUMBER_FILTER_ASSERT_SVH
`define TEXT_LINE_NUMBER_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tlnf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("tlnf assertion failed");

// The expression must hold at every clock edge out of reset.
`define TLNF_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("tlnf assertion failed");

`endif

/* rtl/tlnf_pkg.sv */
package tlnf_pkg;

	// Character codes used by the formatter.
	localparam logic [7:0] CHAR_TAB    = 8'd9;
	localparam logic [7:0] CHAR_NL     = 8'd10;
	localparam logic [7:0] CHAR_SPACE  = 8'd32;
	localparam logic [7:0] CHAR_DOLLAR = 8'd36;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_QMARK  = 8'd63;
	localparam logic [7:0] CHAR_I      = 8'd73;
	localparam logic [7:0] CHAR_CARET  = 8'd94;
	localparam logic [7:0] CHAR_DEL    = 8'd127;

	// Caret notation: control bytes below CTRL_LIMIT print as '^' and byte + CARET_OFFSET.
	localparam logic [7:0] CTRL_LIMIT   = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

	// Largest value of one decimal digit.
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// Configuration port.
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SQUEEZE_BLANK    = 3'd0,
		REG_SHOW_TABS        = 3'd1,
		REG_SHOW_ENDS        = 3'd2,
		REG_NUMBER_ALL       = 3'd3,
		REG_NUMBER_NONBLANK  = 3'd4,
		REG_SHOW_NONPRINTING = 3'd5
	} cfg_reg_t;

	// Command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified input byte: optional line number, then one or two body bytes.
	typedef struct packed {
		logic       has_num;
		logic       two_body;
		logic [7:0] body0;
		logic [7:0] body1;
	} cmd_t;

endpackage

/* rtl/tlnf_front.sv */
module tlnf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             file_start,
	input  logic                             cfg_we,
	input  logic [tlnf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                             cfg_data,
	input  logic                             q_full,
	output logic                             q_push,
	output tlnf_pkg::cmd_t                   q_cmd,
	output logic [NUMBER_DIGITS*4-1:0]       q_digits
);
	import tlnf_pkg::*;

	localparam int CNT_W = NUMBER_DIGITS * 4;

	logic             squeeze_q, tabs_q, ends_q, num_all_q, num_nb_q, nonprint_q;
	logic [7:0]       prev_q;
	logic             blank_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept, prev_nl, blank_mark, is_nl, drop, num, is_caret, blank_next;
	logic             all_nine, carry;
	logic [CNT_W-1:0] cnt_inc;
	logic [3:0]       dig;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			squeeze_q  <= 1'b0;
			tabs_q     <= 1'b0;
			ends_q     <= 1'b0;
			num_all_q  <= 1'b0;
			num_nb_q   <= 1'b0;
			nonprint_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SQUEEZE_BLANK:    squeeze_q  <= cfg_data;
				REG_SHOW_TABS:        tabs_q     <= cfg_data;
				REG_SHOW_ENDS:        ends_q     <= cfg_data;
				REG_NUMBER_ALL:       num_all_q  <= cfg_data;
				REG_NUMBER_NONBLANK:  num_nb_q   <= cfg_data;
				REG_SHOW_NONPRINTING: nonprint_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A transaction is taken whenever the command queue has room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Line context, with a file start acting as a preceding newline.
	assign prev_nl    = file_start || (prev_q == CHAR_NL);
	assign blank_mark = file_start ? 1'b0 : blank_q;
	assign is_nl      = (in_byte == CHAR_NL);
	assign drop       = squeeze_q && is_nl && prev_nl && blank_mark;
	assign num        = prev_nl && ((num_nb_q && !is_nl) || (num_all_q && !num_nb_q));

	// Classify the byte into its body bytes.
	always_comb begin
		q_cmd          = '0;
		q_cmd.has_num  = num;
		q_cmd.body0    = in_byte;
		q_cmd.body1    = CHAR_NL;
		is_caret       = 1'b0;
		if (is_nl) begin
			if (ends_q) begin
				q_cmd.two_body = 1'b1;
				q_cmd.body0    = CHAR_DOLLAR;
			end
		end else if (in_byte == CHAR_TAB && tabs_q) begin
			is_caret       = 1'b1;
			q_cmd.two_body = 1'b1;
			q_cmd.body0    = CHAR_CARET;
			q_cmd.body1    = CHAR_I;
		end else if (nonprint_q && in_byte < CTRL_LIMIT && in_byte != CHAR_TAB) begin
			is_caret       = 1'b1;
			q_cmd.two_body = 1'b1;
			q_cmd.body0    = CHAR_CARET;
			q_cmd.body1    = in_byte + CARET_OFFSET;
		end else if (nonprint_q && in_byte == CHAR_DEL) begin
			is_caret       = 1'b1;
			q_cmd.two_body = 1'b1;
			q_cmd.body0    = CHAR_CARET;
			q_cmd.body1    = CHAR_QMARK;
		end
	end

	assign blank_next = is_nl ? prev_nl : (is_caret ? blank_mark : 1'b0);
	assign q_push     = accept && !drop;
	assign q_digits   = cnt_q;

	// Decimal increment of the line counter, holding at all nines.
	always_comb begin
		all_nine = 1'b1;
		carry    = 1'b1;
		cnt_inc  = cnt_q;
		dig      = '0;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			dig = cnt_q[k*4 +: 4];
			if (dig != DIGIT_MAX) begin
				all_nine = 1'b0;
			end
			if (carry) begin
				if (dig >= DIGIT_MAX) begin
					cnt_inc[k*4 +: 4] = '0;
				end else begin
					cnt_inc[k*4 +: 4] = dig + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nine) begin
			cnt_inc = cnt_q;
		end
	end

	// Line state update on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= CHAR_NL;
			blank_q <= 1'b0;
			cnt_q   <= CNT_W'(1);
		end else if (accept) begin
			if (drop) begin
				prev_q  <= CHAR_NL;
				blank_q <= blank_mark;
			end else begin
				prev_q  <= in_byte;
				blank_q <= blank_next;
				if (num) begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

endmodule

/* rtl/tlnf_queue.sv */
module tlnf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);
	import tlnf_pkg::*;

	logic [WIDTH-1:0]  entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/tlnf_back.sv */
module tlnf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tlnf_pkg::cmd_t             q_cmd,
	input  logic [NUMBER_DIGITS*4-1:0] q_digits,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run
);
	import tlnf_pkg::*;

	localparam int STEP_W = $clog2(NUMBER_DIGITS + 3);
	localparam logic [STEP_W-1:0] POS_TAB   = STEP_W'(NUMBER_DIGITS);
	localparam logic [STEP_W-1:0] POS_BODY0 = STEP_W'(NUMBER_DIGITS + 1);
	localparam logic [STEP_W-1:0] POS_BODY1 = STEP_W'(NUMBER_DIGITS + 2);

	logic [STEP_W-1:0] step_q, pos;
	logic              lead_q, lead_nxt;
	logic              out_valid_q, out_last_q;
	logic [7:0]        out_byte_q, byte_nxt;
	logic              advance, emit, last;
	logic [3:0]        dig;
	logic              low_digit;

	// The output register takes a new byte when empty or being drained.
	assign advance = !out_valid_q || !out_stall;
	assign emit    = q_valid && advance;

	// Position within the command's byte sequence.
	assign pos   = q_cmd.has_num ? step_q : step_q + POS_BODY0;
	assign last  = q_cmd.two_body ? (pos == POS_BODY1) : (pos == POS_BODY0);
	assign q_pop = emit && last;

	// Pick the digit for this position, most significant first.
	always_comb begin
		dig       = '0;
		low_digit = 1'b0;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			if (pos == STEP_W'(NUMBER_DIGITS - 1 - k)) begin
				dig       = q_digits[k*4 +: 4];
				low_digit = (k == 0);
			end
		end
		if (dig > DIGIT_MAX) begin
			dig = DIGIT_MAX;
		end
	end

	// Byte for the current position, with leading zeros shown as spaces.
	always_comb begin
		lead_nxt = lead_q;
		if (pos < POS_TAB) begin
			if (lead_q && dig == '0 && !low_digit) begin
				byte_nxt = CHAR_SPACE;
			end else begin
				byte_nxt = CHAR_ZERO + {4'd0, dig};
				lead_nxt = 1'b0;
			end
		end else if (pos == POS_TAB) begin
			byte_nxt = CHAR_TAB;
		end else if (pos == POS_BODY0) begin
			byte_nxt = q_cmd.body0;
		end else begin
			byte_nxt = q_cmd.body1;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			lead_q <= 1'b1;
		end else if (emit) begin
			step_q <= last ? '0 : step_q + STEP_W'(1);
			lead_q <= last ? 1'b1 : lead_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_nxt;
			out_last_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule

/* rtl/text_line_number_filter.sv */
// Byte-stream text filter with the usual squeeze, numbering, tab, line-end and
// caret-notation options. Each accepted input byte produces zero to
// NUMBER_DIGITS + 3 output bytes; last_of_run marks the final one. The back end
// sends one output byte per clock unless out_stall is high or the queue is empty:
// a plain byte yields one, a caret or "$" expansion two, and a numbered line start
// adds NUMBER_DIGITS + 1 for the number and its tab. The front end classifies one
// input byte per clock while the queue has room, into a 4-entry command queue;
// in_stall rises only when that queue is full. A squeezed blank line is consumed
// and yields nothing. Input passes the queue and the output register first.
// Configuration is to be written while the block is idle; nothing enforces this.
module text_line_number_filter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           file_start,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last_of_run,
	input  logic                           cfg_we,
	input  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                           cfg_data
);
	import tlnf_pkg::*;

	localparam int DIG_W = NUMBER_DIGITS * 4;
	localparam int ENT_W = $bits(cmd_t) + DIG_W;

	logic             q_full, q_push, q_pop, q_valid;
	cmd_t             wr_cmd, rd_cmd;
	logic [DIG_W-1:0] wr_digits, rd_digits;

	// Front end: accepts and classifies input transactions.
	tlnf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.file_start (file_start),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (wr_cmd),
		.q_digits   (wr_digits)
	);

	// Command queue decoupling the two ends.
	tlnf_queue #(.WIDTH(ENT_W)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  ({wr_cmd, wr_digits}),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  ({rd_cmd, rd_digits})
	);

	// Back end: expands each command into output bytes.
	tlnf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (rd_cmd),
		.q_digits    (rd_digits),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

/* rtl/tlnf_checker.sv */
`include "text_line_number_filter_assert.svh"

module tlnf_checker #(
	parameter int NUMBER_DIGITS = 6
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run
);
	import tlnf_pkg::*;

	localparam int RUN_W = $clog2(NUMBER_DIGITS + 4);

	logic [RUN_W-1:0] run_q;
	logic             out_acc;

	assign out_acc = out_valid && !out_stall;

	// Count non-final bytes of the current output run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (out_acc) begin
			if (last_of_run) begin
				run_q <= '0;
			end else if (run_q != {RUN_W{1'b1}}) begin
				run_q <= run_q + RUN_W'(1);
			end
		end
	end

	// A stalled output transaction holds its payload.
	`TLNF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_of_run))

	// A newline byte always closes the run of its input byte.
	`TLNF_ASSERT_IMP(a_nl_last, clk, arst_n, out_valid && out_byte == CHAR_NL, last_of_run)

	// No input byte expands beyond the number, its tab and two body bytes.
	`TLNF_ASSERT_ALWAYS(a_run_len, clk, arst_n, run_q <= RUN_W'(NUMBER_DIGITS + 2))

	// Input side is never stalled when nothing is pending out of reset.
	`TLNF_ASSERT_IMP(a_no_stall_reset, clk, arst_n, $rose(arst_n), !in_stall)

endmodule

bind text_line_number_filter tlnf_checker #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_tlnf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);
